// ===== rtl/dag_shortest_path_core_assert.svh =====
// ----------------------------------------------------------------------------
// dag shortest path assertion macros
// immediate-consequence and next-cycle checks sampled on clk_i
// ----------------------------------------------------------------------------
`ifndef DAG_SHORTEST_PATH_CORE_ASSERT_SVH
`define DAG_SHORTEST_PATH_CORE_ASSERT_SVH

// same-cycle implication
`define DSP_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define DSP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/dsp_pkg.sv =====
// ----------------------------------------------------------------------------
// dsp_pkg
// shared types, codes and constants of the dag shortest path core
// ----------------------------------------------------------------------------
package dsp_pkg;

  localparam int DefMaxVertices = 32;
  localparam int DefMaxEdges    = 256;
  localparam int VertW          = 5;
  localparam int WeightW        = 16;
  localparam int DistW          = 32;
  localparam int CountW         = 6;
  localparam int EdgeW          = 2 * VertW + WeightW;
  localparam int AddrW          = 3;
  localparam int DataW          = 32;

  localparam logic RegVertexCount = 1'b0;

  localparam logic signed [DistW-1:0] DistMax = 32'sh7fff_ffff;
  localparam logic signed [DistW-1:0] DistMin = 32'sh8000_0000;

  typedef enum logic [1:0] {
    ACT_CLEAR = 2'd0,
    ACT_ADD   = 2'd1,
    ACT_RUN   = 2'd2,
    ACT_NONE  = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_DFS_ROOT,
    S_DFS_FETCH,
    S_DFS_CHECK,
    S_RLX_VTX,
    S_RLX_LOAD,
    S_RLX_FETCH,
    S_RLX_CHECK,
    S_RLX_UPD,
    S_EMIT_RD,
    S_EMIT_OUT
  } state_e;

  typedef struct packed {
    logic [1:0]                action;
    logic [VertW-1:0]          from_vertex;
    logic [VertW-1:0]          to_vertex;
    logic signed [WeightW-1:0] edge_weight;
    logic [VertW-1:0]          source_vertex;
  } item_t;

  typedef struct packed {
    logic [VertW-1:0]        vertex_index;
    logic signed [DistW-1:0] path_distance;
    logic                    reachable;
    logic [1:0]              status;
    logic                    last;
  } result_t;

  typedef struct packed {
    logic latch_item;
    logic tbl_clear;
    logic tbl_add;
    logic emit_status;
    logic run_init;
    logic root_next;
    logic root_push;
    logic dfs_fetch;
    logic dfs_pop;
    logic dfs_push;
    logic dfs_skip;
    logic relax_init;
    logic vtx_skip;
    logic vtx_read;
    logic vtx_load;
    logic rlx_fetch;
    logic rlx_match;
    logic rlx_next;
    logic rlx_update;
    logic emit_read;
    logic emit_load;
  } cmd_t;

  typedef struct packed {
    logic [1:0] action;
    logic       add_bad;
    logic       add_full;
    logic       src_bad;
    logic       root_done;
    logic       root_visited;
    logic       top_in_range;
    logic       depth_one;
    logic       push_ok;
    logic       pos_zero;
    logic       cur_reach;
    logic       e_in_range;
    logic       edge_match;
    logic       emit_last;
    logic       out_free;
  } sts_t;

endpackage

// ===== rtl/dag_shortest_path_core.sv =====
// ----------------------------------------------------------------------------
// dag_shortest_path_core
// single-source shortest paths over a stored directed acyclic edge table
// ----------------------------------------------------------------------------
// One item at a time. Clear, add edge and a run with a bad source go through
// decode and back to idle; add edge and a bad-source run wait for a free
// output. A run orders the vertices by depth-first search, then relaxes edges
// in reverse order and returns one distance item per vertex: every edge scan step
// is a fetch and a check because the edge table is a memory with registered
// read. Every vertex scans the whole table once during ordering. Relaxation
// scans the table for each reachable vertex from the source onward in the
// order, with an update per matching out-edge, and skips every other position.
// Each output item is a distance store read, then a load of the output register.
// No clearing pass after reset. Configuration writes go through the APB port;
// the user must make them only while the block is idle; the block does not enforce it.
module dag_shortest_path_core import dsp_pkg::*; #(
  parameter int MAX_VERTICES = DefMaxVertices,
  parameter int MAX_EDGES    = DefMaxEdges
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  item_t            in_item_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output result_t          out_item_o,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready
);

  localparam int VCW = $clog2(MAX_VERTICES + 1);

  logic [VCW-1:0]    vcount_q;
  logic [CountW-1:0] wr_val;
  logic              wr_en;
  cmd_t              cmd;
  sts_t              sts;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr[2] == RegVertexCount);
  assign wr_val = pwdata[CountW-1:0];
  assign prdata = (paddr[2] == RegVertexCount) ? DataW'(vcount_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcount_q <= VCW'(MAX_VERTICES);
    end else if (wr_en) begin
      if (wr_val == '0) begin
        vcount_q <= VCW'(1);
      end else if (32'(wr_val) > MAX_VERTICES) begin
        vcount_q <= VCW'(MAX_VERTICES);
      end else begin
        vcount_q <= VCW'(wr_val);
      end
    end
  end

  dsp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  dsp_datapath #(
    .MAX_VERTICES (MAX_VERTICES),
    .MAX_EDGES    (MAX_EDGES)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_item_i      (in_item_i),
    .vertex_count_i (vcount_q),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_item_o     (out_item_o)
  );

endmodule

// ===== rtl/dsp_ram.sv =====
// ----------------------------------------------------------------------------
// dsp_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module dsp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/dsp_ctrl.sv =====
// ----------------------------------------------------------------------------
// dsp_ctrl
// sequencer for table updates, depth-first ordering, relaxation and output
// ----------------------------------------------------------------------------
module dsp_ctrl import dsp_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = (state_q != S_IDLE);
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch_item = 1'b1;
          state_d          = S_DECODE;
        end
      end
      S_DECODE: begin
        case (sts_i.action)
          ACT_CLEAR: begin
            cmd_o.tbl_clear = 1'b1;
            state_d         = S_IDLE;
          end
          ACT_ADD: begin
            if (sts_i.out_free) begin
              cmd_o.tbl_add     = 1'b1;
              cmd_o.emit_status = 1'b1;
              state_d           = S_IDLE;
            end
          end
          ACT_RUN: begin
            if (sts_i.src_bad) begin
              if (sts_i.out_free) begin
                cmd_o.emit_status = 1'b1;
                state_d           = S_IDLE;
              end
            end else begin
              cmd_o.run_init = 1'b1;
              state_d        = S_DFS_ROOT;
            end
          end
          default: state_d = S_IDLE;
        endcase
      end
      S_DFS_ROOT: begin
        if (sts_i.root_done) begin
          cmd_o.relax_init = 1'b1;
          state_d          = S_RLX_VTX;
        end else if (sts_i.root_visited) begin
          cmd_o.root_next = 1'b1;
        end else begin
          cmd_o.root_push = 1'b1;
          state_d         = S_DFS_FETCH;
        end
      end
      S_DFS_FETCH: begin
        if (sts_i.top_in_range) begin
          cmd_o.dfs_fetch = 1'b1;
          state_d         = S_DFS_CHECK;
        end else begin
          cmd_o.dfs_pop = 1'b1;
          if (sts_i.depth_one) begin
            cmd_o.root_next = 1'b1;
            state_d         = S_DFS_ROOT;
          end
        end
      end
      S_DFS_CHECK: begin
        if (sts_i.push_ok) begin
          cmd_o.dfs_push = 1'b1;
        end else begin
          cmd_o.dfs_skip = 1'b1;
        end
        state_d = S_DFS_FETCH;
      end
      S_RLX_VTX: begin
        if (sts_i.pos_zero) begin
          state_d = S_EMIT_RD;
        end else if (!sts_i.cur_reach) begin
          cmd_o.vtx_skip = 1'b1;
        end else begin
          cmd_o.vtx_read = 1'b1;
          state_d        = S_RLX_LOAD;
        end
      end
      S_RLX_LOAD: begin
        cmd_o.vtx_load = 1'b1;
        state_d        = S_RLX_FETCH;
      end
      S_RLX_FETCH: begin
        if (sts_i.e_in_range) begin
          cmd_o.rlx_fetch = 1'b1;
          state_d         = S_RLX_CHECK;
        end else begin
          cmd_o.vtx_skip = 1'b1;
          state_d        = S_RLX_VTX;
        end
      end
      S_RLX_CHECK: begin
        if (sts_i.edge_match) begin
          cmd_o.rlx_match = 1'b1;
          state_d         = S_RLX_UPD;
        end else begin
          cmd_o.rlx_next = 1'b1;
          state_d        = S_RLX_FETCH;
        end
      end
      S_RLX_UPD: begin
        cmd_o.rlx_update = 1'b1;
        state_d          = S_RLX_FETCH;
      end
      S_EMIT_RD: begin
        cmd_o.emit_read = 1'b1;
        state_d         = S_EMIT_OUT;
      end
      S_EMIT_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.emit_load = 1'b1;
          state_d         = sts_i.emit_last ? S_IDLE : S_EMIT_RD;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

// ===== rtl/dsp_datapath.sv =====
// ----------------------------------------------------------------------------
// dsp_datapath
// edge table, traversal stack, ordering, distance store and output register
// ----------------------------------------------------------------------------
`include "dag_shortest_path_core_assert.svh"

module dsp_datapath import dsp_pkg::*; #(
  parameter int MAX_VERTICES = DefMaxVertices,
  parameter int MAX_EDGES    = DefMaxEdges,
  localparam int VCW = $clog2(MAX_VERTICES + 1)
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  item_t          in_item_i,
  input  logic [VCW-1:0] vertex_count_i,
  input  cmd_t           cmd_i,
  output sts_t           sts_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output result_t        out_item_o
);

  localparam int VIW = $clog2(MAX_VERTICES);
  localparam int ETW = $clog2(MAX_EDGES + 1);
  localparam int EAW = $clog2(MAX_EDGES);

  typedef logic [VIW-1:0] vidx_t;

  item_t                   item_q;
  logic [ETW-1:0]          edge_total_q;
  logic [ETW-1:0]          e_q;
  logic [MAX_VERTICES-1:0] visited_q;
  logic [MAX_VERTICES-1:0] reach_q;
  vidx_t                   stk_v_q [MAX_VERTICES];
  logic [ETW-1:0]          stk_n_q [MAX_VERTICES];
  vidx_t                   order_q [MAX_VERTICES];
  logic [VCW-1:0]          depth_q;
  logic [VCW-1:0]          done_q;
  logic [VCW-1:0]          root_q;
  logic [VCW-1:0]          pos_q;
  logic [VCW-1:0]          start_pos_q;
  logic [VCW-1:0]          i_q;
  vidx_t                   cur_q;
  vidx_t                   dst_q;
  logic signed [DistW-1:0] curdist_q;
  logic signed [WeightW-1:0] cost_q;
  result_t                 out_q;
  logic                    out_valid_q;

  logic                    edge_we;
  logic                    edge_re;
  logic [EAW-1:0]          edge_raddr;
  logic [EdgeW-1:0]        edge_wdata;
  logic [EdgeW-1:0]        edge_rdata;
  logic [VertW-1:0]        e_start;
  logic [VertW-1:0]        e_end;
  logic signed [WeightW-1:0] e_cost;
  logic                    e_live;

  logic                    best_we;
  vidx_t                   best_waddr;
  logic signed [DistW-1:0] best_wdata;
  logic                    best_re;
  vidx_t                   best_raddr;
  logic signed [DistW-1:0] best_rdata;

  vidx_t                   top_idx;
  vidx_t                   src_idx;
  vidx_t                   cur_idx;
  vidx_t                   end_idx;
  logic signed [DistW:0]   sum_wide;
  logic signed [DistW-1:0] sum_sat;
  logic                    better;
  logic [1:0]              add_code;

  assign top_idx = vidx_t'(depth_q - 1'b1);
  assign src_idx = vidx_t'(item_q.source_vertex);
  assign cur_idx = order_q[vidx_t'(pos_q - 1'b1)];

  assign e_start = edge_rdata[EdgeW-1 -: VertW];
  assign e_end   = edge_rdata[WeightW +: VertW];
  assign e_cost  = edge_rdata[WeightW-1:0];
  assign end_idx = vidx_t'(e_end);
  assign e_live  = (32'(e_start) < 32'(vertex_count_i)) &&
                   (32'(e_end) < 32'(vertex_count_i));

  // status toward the sequencer
  always_comb begin
    sts_o.action       = item_q.action;
    sts_o.add_bad      = (32'(item_q.from_vertex) >= 32'(vertex_count_i)) ||
                         (32'(item_q.to_vertex) >= 32'(vertex_count_i));
    sts_o.add_full     = (32'(edge_total_q) >= MAX_EDGES);
    sts_o.src_bad      = (32'(item_q.source_vertex) >= 32'(vertex_count_i));
    sts_o.root_done    = (root_q == vertex_count_i);
    sts_o.root_visited = visited_q[vidx_t'(root_q)];
    sts_o.top_in_range = (stk_n_q[top_idx] < edge_total_q);
    sts_o.depth_one    = (depth_q == VCW'(1));
    sts_o.push_ok      = (32'(e_start) == 32'(stk_v_q[top_idx])) && e_live &&
                         !visited_q[end_idx] && (32'(depth_q) < MAX_VERTICES);
    sts_o.pos_zero     = (pos_q == '0);
    sts_o.cur_reach    = reach_q[cur_idx];
    sts_o.e_in_range   = (e_q < edge_total_q);
    sts_o.edge_match   = (32'(e_start) == 32'(cur_q)) && e_live;
    sts_o.emit_last    = (i_q == vertex_count_i - 1'b1);
    sts_o.out_free     = !out_valid_q || !out_stall_i;
  end

  assign add_code = sts_o.add_bad  ? ST_RANGE :
                    sts_o.add_full ? ST_FULL  : ST_OK;

  // saturating relaxation sum and compare
  always_comb begin
    sum_wide = {curdist_q[DistW-1], curdist_q} + (DistW+1)'(cost_q);
    if (sum_wide[DistW] != sum_wide[DistW-1]) begin
      sum_sat = sum_wide[DistW] ? DistMin : DistMax;
    end else begin
      sum_sat = sum_wide[DistW-1:0];
    end
    better = !reach_q[dst_q] || (sum_sat < best_rdata);
  end

  // edge table
  assign edge_we    = cmd_i.tbl_add && !sts_o.add_bad && !sts_o.add_full;
  assign edge_wdata = {item_q.from_vertex, item_q.to_vertex, item_q.edge_weight};
  assign edge_re    = cmd_i.dfs_fetch || cmd_i.rlx_fetch;
  assign edge_raddr = cmd_i.dfs_fetch ? EAW'(stk_n_q[top_idx]) : EAW'(e_q);

  dsp_ram #(
    .WIDTH (EdgeW),
    .DEPTH (MAX_EDGES)
  ) u_edge_ram (
    .clk_i   (clk_i),
    .we_i    (edge_we),
    .waddr_i (EAW'(edge_total_q)),
    .wdata_i (edge_wdata),
    .re_i    (edge_re),
    .raddr_i (edge_raddr),
    .rdata_o (edge_rdata)
  );

  // distance store
  always_comb begin
    best_we    = cmd_i.relax_init || (cmd_i.rlx_update && better);
    best_waddr = cmd_i.relax_init ? src_idx : dst_q;
    best_wdata = cmd_i.relax_init ? '0 : sum_sat;
    best_re    = cmd_i.vtx_read || cmd_i.rlx_match || cmd_i.emit_read;
    if (cmd_i.vtx_read) begin
      best_raddr = cur_idx;
    end else if (cmd_i.rlx_match) begin
      best_raddr = end_idx;
    end else begin
      best_raddr = vidx_t'(i_q);
    end
  end

  dsp_ram #(
    .WIDTH (DistW),
    .DEPTH (MAX_VERTICES)
  ) u_best_ram (
    .clk_i   (clk_i),
    .we_i    (best_we),
    .waddr_i (best_waddr),
    .wdata_i (best_wdata),
    .re_i    (best_re),
    .raddr_i (best_raddr),
    .rdata_o (best_rdata)
  );

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      edge_total_q <= '0;
      visited_q    <= '0;
      reach_q      <= '0;
      depth_q      <= '0;
      done_q       <= '0;
      root_q       <= '0;
      pos_q        <= '0;
      start_pos_q  <= '0;
      i_q          <= '0;
      e_q          <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cmd_i.tbl_clear) begin
        edge_total_q <= '0;
      end else if (edge_we) begin
        edge_total_q <= edge_total_q + 1'b1;
      end

      if (cmd_i.run_init) begin
        visited_q   <= '0;
        root_q      <= '0;
        done_q      <= '0;
        depth_q     <= '0;
        start_pos_q <= '0;
      end
      if (cmd_i.root_next) begin
        root_q <= root_q + 1'b1;
      end
      if (cmd_i.root_push) begin
        visited_q[vidx_t'(root_q)] <= 1'b1;
        depth_q                    <= VCW'(1);
      end
      if (cmd_i.dfs_fetch) begin
        e_q <= stk_n_q[top_idx];
      end
      if (cmd_i.dfs_push) begin
        visited_q[end_idx] <= 1'b1;
        depth_q            <= depth_q + 1'b1;
      end
      if (cmd_i.dfs_pop) begin
        depth_q <= depth_q - 1'b1;
        if (32'(done_q) < MAX_VERTICES) begin
          done_q <= done_q + 1'b1;
          if (stk_v_q[top_idx] == src_idx) begin
            start_pos_q <= done_q + 1'b1;
          end
        end
      end

      if (cmd_i.relax_init) begin
        reach_q          <= '0;
        reach_q[src_idx] <= 1'b1;
        pos_q            <= start_pos_q;
        i_q              <= '0;
      end
      if (cmd_i.vtx_skip) begin
        pos_q <= pos_q - 1'b1;
      end
      if (cmd_i.vtx_load) begin
        e_q <= '0;
      end
      if (cmd_i.rlx_next || cmd_i.rlx_update) begin
        e_q <= e_q + 1'b1;
      end
      if (cmd_i.rlx_update && better) begin
        reach_q[dst_q] <= 1'b1;
      end
      if (cmd_i.emit_load) begin
        i_q <= i_q + 1'b1;
      end

      if (cmd_i.emit_status || cmd_i.emit_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_item) begin
      item_q <= in_item_i;
    end
    if (cmd_i.root_push) begin
      stk_v_q[0] <= vidx_t'(root_q);
      stk_n_q[0] <= '0;
    end
    if (cmd_i.dfs_push || cmd_i.dfs_skip) begin
      stk_n_q[top_idx] <= e_q + 1'b1;
    end
    if (cmd_i.dfs_push) begin
      stk_v_q[vidx_t'(depth_q)] <= end_idx;
      stk_n_q[vidx_t'(depth_q)] <= '0;
    end
    if (cmd_i.dfs_pop && (32'(done_q) < MAX_VERTICES)) begin
      order_q[vidx_t'(done_q)] <= stk_v_q[top_idx];
    end
    if (cmd_i.vtx_read) begin
      cur_q <= cur_idx;
    end
    if (cmd_i.vtx_load) begin
      curdist_q <= best_rdata;
    end
    if (cmd_i.rlx_match) begin
      dst_q  <= end_idx;
      cost_q <= e_cost;
    end
    if (cmd_i.rlx_update && better && (dst_q == cur_q)) begin
      curdist_q <= sum_sat;
    end
    if (cmd_i.emit_status) begin
      out_q.vertex_index  <= '0;
      out_q.path_distance <= '0;
      out_q.reachable     <= 1'b0;
      out_q.status        <= (item_q.action == ACT_ADD) ? add_code : ST_RANGE;
      out_q.last          <= 1'b1;
    end else if (cmd_i.emit_load) begin
      out_q.vertex_index  <= VertW'(i_q);
      out_q.path_distance <= reach_q[vidx_t'(i_q)] ? best_rdata : DistMax;
      out_q.reachable     <= reach_q[vidx_t'(i_q)];
      out_q.status        <= ST_OK;
      out_q.last          <= sts_o.emit_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  `DSP_ASSERT_NEXT(a_add_counts, edge_we, edge_total_q == $past(edge_total_q) + 1'b1, "edge add did not advance the table count")
  `DSP_ASSERT_IMPL(a_push_room, cmd_i.dfs_push, 32'(depth_q) < MAX_VERTICES, "traversal push beyond stack depth")
  `DSP_ASSERT_NEXT(a_emit_shows, cmd_i.emit_load, out_valid_q && (out_q.last == $past(sts_o.emit_last)), "distance item not presented with its last flag")

endmodule

// ===== verif/dag_shortest_path_core_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dag_shortest_path_core_test
// Drives edge-table clears, edge adds and shortest-path runs into the core
// under random gaps on both sides and one long output hold-off. Every accepted
// item is fed to a local predictor of the edge table, the depth-first ordering
// and the relaxation. Each returned item is compared field by field with the
// oldest expected one. The vertex count register is changed between phases.
// ----------------------------------------------------------------------------
module dag_shortest_path_core_test;
  import dsp_pkg::*;

  localparam int NV         = 32;
  localparam int NE         = 256;
  localparam int IdleLimit  = 200000;
  localparam int HoldCycles = 400;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             in_valid_i = 1'b0;
  logic             in_stall_o;
  item_t            in_item_i = '0;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  result_t          out_item_o;
  logic             psel = 1'b0;
  logic             penable = 1'b0;
  logic             pwrite = 1'b0;
  logic [AddrW-1:0] paddr = '0;
  logic [DataW-1:0] pwdata = '0;
  logic [DataW-1:0] prdata;
  logic             pready;

  dag_shortest_path_core dut (.*);

  always #1 clk_i = ~clk_i;

  // predictor state
  logic [4:0]         tbl_from [NE];
  logic [4:0]         tbl_to   [NE];
  logic signed [15:0] tbl_cost [NE];
  int                 tbl_count = 0;
  int                 vertex_limit = NV;

  item_t   pending_items[$];
  result_t expected_results[$];
  int      mismatches = 0;
  int      results_seen = 0;
  int      idle_cycles = 0;
  bit      quiet = 1'b0;
  bit      hold_done = 1'b0;
  int      hold_left = 0;
  int      send_gap = 0;
  int      stall_gap = 0;

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic bit edge_in_use(int e);
    return tbl_from[e] < vertex_limit && tbl_to[e] < vertex_limit;
  endfunction

  function automatic void predict_distances(item_t it);
    result_t r;
    bit      visited [NV];
    int      order [NV];
    int      walk_v [NV];
    int      walk_e [NV];
    longint  best_dist [NV];
    bit      reach [NV];
    int      done, depth, top, vtx, e, nxt, root, start, cur, dst, src;
    bit      pushed;
    longint  sum;
    r = '0;
    r.last = 1'b1;
    case (action_e'(it.action))
      ACT_CLEAR: tbl_count = 0;
      ACT_ADD: begin
        if (it.from_vertex >= vertex_limit || it.to_vertex >= vertex_limit) begin
          r.status = ST_RANGE;
        end else if (tbl_count >= NE) begin
          r.status = ST_FULL;
        end else begin
          r.status = ST_OK;
          tbl_from[tbl_count] = it.from_vertex;
          tbl_to[tbl_count]   = it.to_vertex;
          tbl_cost[tbl_count] = it.edge_weight;
          tbl_count++;
        end
        expected_results.insert(expected_results.size(), r);
      end
      ACT_RUN: begin
        src = it.source_vertex;
        if (src >= vertex_limit) begin
          r.status = ST_RANGE;
          expected_results.insert(expected_results.size(), r);
        end else begin
          done = 0;
          foreach (visited[i]) begin
            visited[i] = 1'b0;
            order[i] = 0;
          end
          for (root = 0; root < vertex_limit; root++) begin
            if (visited[root]) continue;
            visited[root] = 1'b1;
            walk_v[0] = root;
            walk_e[0] = 0;
            depth = 1;
            while (depth > 0) begin
              top = depth - 1;
              vtx = walk_v[top];
              e = walk_e[top];
              pushed = 1'b0;
              while (e < tbl_count) begin
                if (tbl_from[e] == vtx && edge_in_use(e) && !visited[tbl_to[e]]
                    && depth < NV) begin
                  nxt = tbl_to[e];
                  walk_e[top] = e + 1;
                  visited[nxt] = 1'b1;
                  walk_v[depth] = nxt;
                  walk_e[depth] = 0;
                  depth++;
                  pushed = 1'b1;
                  break;
                end
                e++;
              end
              if (!pushed) begin
                depth--;
                if (done < NV) order[done++] = vtx;
              end
            end
          end
          for (int i = 0; i < vertex_limit; i++) begin
            best_dist[i] = 64'sd2147483647;
            reach[i] = 1'b0;
          end
          best_dist[src] = 0;
          reach[src] = 1'b1;
          start = 0;
          for (int p = vertex_limit; p > 0; p--) begin
            if (order[p-1] == src) begin
              start = p;
              break;
            end
          end
          for (int p = start; p > 0; p--) begin
            cur = order[p-1];
            if (!reach[cur]) continue;
            for (int k = 0; k < tbl_count; k++) begin
              if (tbl_from[k] != cur || !edge_in_use(k)) continue;
              dst = tbl_to[k];
              sum = best_dist[cur] + longint'(tbl_cost[k]);
              if (sum > 64'sd2147483647) sum = 64'sd2147483647;
              if (sum < -64'sd2147483648) sum = -64'sd2147483648;
              if (!reach[dst] || sum < best_dist[dst]) begin
                best_dist[dst] = sum;
                reach[dst] = 1'b1;
              end
            end
          end
          for (int i = 0; i < vertex_limit; i++) begin
            r = '0;
            r.vertex_index  = 5'(i);
            r.path_distance = best_dist[i][31:0];
            r.reachable     = reach[i];
            r.status        = ST_OK;
            r.last          = (i + 1 == vertex_limit);
            expected_results.insert(expected_results.size(), r);
          end
        end
      end
      default: ;
    endcase
  endfunction

  // sender
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_item_i  <= '0;
      send_gap   <= 0;
    end else if (!in_valid_i || !in_stall_o) begin
      if (send_gap > 0) begin
        send_gap   <= send_gap - 1;
        in_valid_i <= 1'b0;
      end else if (pending_items.size() > 0) begin
        in_item_i  <= pending_items.pop_front();
        in_valid_i <= 1'b1;
        send_gap   <= gap_len();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver stall, with one long hold-off
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_gap   <= 0;
    end else if (hold_left > 0) begin
      hold_left   <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else if (!hold_done && results_seen >= 100) begin
      hold_done   <= 1'b1;
      hold_left   <= HoldCycles;
      out_stall_i <= 1'b1;
    end else if (stall_gap > 0) begin
      stall_gap   <= stall_gap - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
      stall_gap   <= gap_len();
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) predict_distances(in_item_i);
      if (out_valid_o && !out_stall_i) begin
        results_seen <= results_seen + 1;
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected item: %p", out_item_o);
        end else begin
          result_t want;
          want = expected_results.pop_front();
          if (out_item_o !== want) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch: expected %p got %p", want, out_item_o);
          end
        end
      end
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || psel)
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
    end
  end

  always @(posedge clk_i) begin
    if (idle_cycles >= IdleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic write_vertex_count(int value);
    int v;
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= AddrW'(RegVertexCount) << 2;
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    v = value & 6'h3f;
    if (v < 1) v = 1;
    if (v > NV) v = NV;
    vertex_limit = v;
  endtask

  task automatic drain();
    while (pending_items.size() > 0 || in_valid_i || expected_results.size() > 0)
      @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  function automatic void queue_item(action_e a, int f, int t, int w, int s);
    item_t it;
    it.action        = a;
    it.from_vertex   = 5'(f);
    it.to_vertex     = 5'(t);
    it.edge_weight   = 16'(w);
    it.source_vertex = 5'(s);
    pending_items.insert(pending_items.size(), it);
  endfunction

  function automatic void queue_graph(int nv, int adds, int runs);
    int f, t;
    queue_item(ACT_CLEAR, $urandom, $urandom, $urandom, $urandom);
    for (int i = 0; i < adds; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        queue_item(ACT_ADD, $urandom, $urandom, $urandom, $urandom);
      end else begin
        f = $urandom_range(0, nv - 1);
        t = $urandom_range(0, nv - 1);
        if (f > t) begin
          int x;
          x = f; f = t; t = x;
        end
        if (f == t && t < nv - 1) t++;
        queue_item(ACT_ADD, f, t, $urandom, $urandom);
      end
      if ($urandom_range(0, 29) == 0)
        queue_item(ACT_NONE, $urandom, $urandom, $urandom, $urandom);
    end
    for (int i = 0; i < runs; i++)
      queue_item(ACT_RUN, $urandom, $urandom, $urandom,
                 ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, nv / 2));
  endfunction

  initial begin
    int nv;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // extremes at full size, a cycle, ignored action, bad register values
    write_vertex_count(63);
    quiet = 1'b1;
    queue_item(ACT_ADD, 0, 31, 32767, 0);
    queue_item(ACT_ADD, 31, 0, -32768, 31);
    queue_item(ACT_ADD, 20, 1, -5, 0);
    queue_item(ACT_ADD, 0, 20, -32768, 0);
    queue_item(ACT_NONE, 31, 31, -1, 31);
    queue_item(ACT_RUN, 0, 0, 0, 0);
    queue_item(ACT_RUN, 31, 31, -1, 31);
    drain();
    quiet = 1'b0;
    // stale edges and out-of-range cases
    write_vertex_count(5);
    queue_item(ACT_ADD, 7, 1, 3, 0);
    queue_item(ACT_ADD, 1, 7, 3, 0);
    queue_item(ACT_ADD, 0, 1, 100, 0);
    queue_item(ACT_ADD, 1, 4, -200, 0);
    queue_item(ACT_RUN, 0, 0, 0, 6);
    queue_item(ACT_RUN, 0, 0, 0, 0);
    queue_item(ACT_RUN, 0, 0, 0, 4);
    queue_item(ACT_CLEAR, 0, 0, 0, 0);
    queue_item(ACT_RUN, 0, 0, 0, 1);
    drain();
    write_vertex_count(0);
    queue_item(ACT_ADD, 0, 0, 7, 0);
    queue_item(ACT_ADD, 0, 1, 7, 0);
    queue_item(ACT_RUN, 0, 0, 0, 0);
    queue_item(ACT_RUN, 0, 0, 0, 1);
    drain();
    // random graphs
    for (int ph = 0; ph < 9; ph++) begin
      quiet = (ph == 3);
      case (ph)
        0: nv = 32;
        4: nv = 1;
        default: nv = $urandom_range(2, 12);
      endcase
      write_vertex_count(nv);
      queue_graph(nv, $urandom_range(8, 18), $urandom_range(2, 3));
      drain();
    end
    repeat (100) @(posedge clk_i);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
